### rtl/gate_access_relay_fsm_core_assert.svh
// Assertion macros shared by the gate relay RTL.
// Clock clk_i and active-low reset rst_ni are taken from the including module.
`ifndef GATE_ACCESS_RELAY_FSM_CORE_ASSERT_SVH
`define GATE_ACCESS_RELAY_FSM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define GAR_ASSERT(lbl, prop, msg)
`define GAR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

### rtl/gar_pkg.sv
`default_nettype none

package gar_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  // result queue geometry
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_BEGIN      = 4'd1,
    CMD_AUTH_PEND  = 4'd2,
    CMD_AUTH_OK    = 4'd3,
    CMD_LOCAL_OPEN = 4'd4,
    CMD_ABORT      = 4'd5,
    CMD_REMOTE_OPEN = 4'd6,
    CMD_PREARM     = 4'd7,
    CMD_SENSOR     = 4'd8,
    CMD_TIMER_OFF  = 4'd9,
    CMD_FAILSAFE   = 4'd10,
    CMD_CLEANUP    = 4'd11
  } cmd_e;

  typedef enum logic [4:0] {
    EV_NONE                = 5'd0,
    EV_DOOR_CLOSE_FS       = 5'd1,
    EV_DOOR_CLOSE          = 5'd2,
    EV_SESSION_TERM_FS     = 5'd3,
    EV_SESSION_DONE        = 5'd4,
    EV_AUTH_PEND_TIMEOUT   = 5'd5,
    EV_SESSION_TERM        = 5'd6,
    EV_ARM_EXPIRED         = 5'd7,
    EV_GATE_IDLE           = 5'd8,
    EV_AUTH_PENDING        = 5'd9,
    EV_AUTH_OPEN_REJ       = 5'd10,
    EV_AUTH_ARMED          = 5'd11,
    EV_LOCAL_OPEN_REJ      = 5'd12,
    EV_RELAY_ON_LOCAL      = 5'd13,
    EV_AUTH_ABORTED        = 5'd14,
    EV_MANUAL_OPEN_REJ     = 5'd15,
    EV_RELAY_ON_MANUAL     = 5'd16,
    EV_PRE_ARMED           = 5'd17,
    EV_SENSOR_DETECTED     = 5'd18,
    EV_RELAY_ON_SENSOR     = 5'd19
  } evt_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_PEND  = 5'b00010,
    PH_ARMED = 5'b00100,
    PH_HOLD  = 5'b01000,
    PH_COOL  = 5'b10000
  } phase_e;

  localparam logic [2:0] PHC_IDLE  = 3'd0;
  localparam logic [2:0] PHC_PEND  = 3'd1;
  localparam logic [2:0] PHC_ARMED = 3'd2;
  localparam logic [2:0] PHC_HOLD  = 3'd3;
  localparam logic [2:0] PHC_COOL  = 3'd4;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] now_time;
    logic [31:0] first_duration;
    logic [31:0] cooldown_length;
  } gar_in_t;

  typedef struct packed {
    logic [4:0] event_code;
    logic       accepted;
    logic       relay_on;
    logic [2:0] gate_phase;
    logic       last_result;
  } gar_out_t;

  // results handed from the engine to the result queue
  typedef struct packed {
    logic [1:0] count;
    gar_out_t   res0;
    gar_out_t   res1;
  } gar_push_t;

  function automatic logic [2:0] phase_code(phase_e p);
    logic [2:0] c;
    case (p)
      PH_IDLE:  c = PHC_IDLE;
      PH_PEND:  c = PHC_PEND;
      PH_ARMED: c = PHC_ARMED;
      PH_HOLD:  c = PHC_HOLD;
      PH_COOL:  c = PHC_COOL;
      default:  c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/gar_engine.sv
`default_nettype none

`include "gate_access_relay_fsm_core_assert.svh"

module gar_engine #(
  parameter int unsigned TIME_BITS = gar_pkg::TIME_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire gar_pkg::gar_in_t item_i,
  output gar_pkg::gar_push_t   push_o
);

  gar_pkg::phase_e phase_q, phase_d;
  logic            armed_q, armed_d;
  logic            relay_q, relay_d;
  logic [TIME_BITS-1:0] ps_q, ps_d;   // phase start
  logic [TIME_BITS-1:0] as_q, as_d;   // arm start
  logic [31:0] aw_q, aw_d;            // arm window
  logic [31:0] hw_q, hw_d;            // hold window
  logic [31:0] cw_q, cw_d;            // cooldown window

  logic [TIME_BITS-1:0] now_t;
  logic el_pend, el_arm, el_hold, el_cool, hold_on, acc, sensor_hit;
  logic [1:0] n;
  gar_pkg::evt_e ev0, ev1;

  assign now_t   = TIME_BITS'(item_i.now_time);
  assign el_pend = (now_t - ps_q) >= TIME_BITS'(aw_q);
  assign el_arm  = (now_t - as_q) >= TIME_BITS'(aw_q);
  assign el_hold = (now_t - ps_q) >= TIME_BITS'(hw_q);
  assign el_cool = (now_t - ps_q) >= TIME_BITS'(cw_q);
  assign hold_on = (phase_q == gar_pkg::PH_HOLD) && relay_q;

  always_comb begin
    phase_d = phase_q;
    armed_d = armed_q;
    relay_d = relay_q;
    ps_d = ps_q;
    as_d = as_q;
    aw_d = aw_q;
    hw_d = hw_q;
    cw_d = cw_q;
    acc = 1'b0;
    n = 2'd0;
    ev0 = gar_pkg::EV_NONE;
    ev1 = gar_pkg::EV_NONE;
    sensor_hit = 1'b0;
    case (item_i.command)
      gar_pkg::CMD_TICK: begin
        case (phase_q)
          gar_pkg::PH_PEND: begin
            if (el_pend) begin
              phase_d = gar_pkg::PH_IDLE;
              ps_d = now_t;
              acc = 1'b1;
              n = 2'd2;
              ev0 = gar_pkg::EV_AUTH_PEND_TIMEOUT;
              ev1 = gar_pkg::EV_SESSION_TERM;
            end
          end
          gar_pkg::PH_ARMED: begin
            if (armed_q && el_arm) begin
              armed_d = 1'b0;
              phase_d = gar_pkg::PH_IDLE;
              ps_d = now_t;
              acc = 1'b1;
              n = 2'd2;
              ev0 = gar_pkg::EV_ARM_EXPIRED;
              ev1 = gar_pkg::EV_SESSION_TERM;
            end
          end
          gar_pkg::PH_HOLD: begin
            if (el_hold && relay_q) begin
              relay_d = 1'b0;
              armed_d = 1'b0;
              phase_d = gar_pkg::PH_COOL;
              ps_d = now_t;
              acc = 1'b1;
              n = 2'd2;
              ev0 = gar_pkg::EV_DOOR_CLOSE;
              ev1 = gar_pkg::EV_SESSION_DONE;
            end
          end
          gar_pkg::PH_COOL: begin
            if (el_cool) begin
              phase_d = gar_pkg::PH_IDLE;
              ps_d = now_t;
              acc = 1'b1;
              n = 2'd1;
              ev0 = gar_pkg::EV_GATE_IDLE;
            end
          end
          default: ;
        endcase
      end
      gar_pkg::CMD_BEGIN, gar_pkg::CMD_CLEANUP: begin
        phase_d = gar_pkg::PH_IDLE;
        armed_d = 1'b0;
        relay_d = 1'b0;
        ps_d = now_t;
        acc = 1'b1;
      end
      gar_pkg::CMD_AUTH_PEND: begin
        if (phase_q == gar_pkg::PH_IDLE && !relay_q) begin
          armed_d = 1'b0;
          phase_d = gar_pkg::PH_PEND;
          ps_d = now_t;
          aw_d = item_i.first_duration;
          acc = 1'b1;
          n = 2'd1;
          ev0 = gar_pkg::EV_AUTH_PENDING;
        end
      end
      gar_pkg::CMD_AUTH_OK: begin
        n = 2'd1;
        if (phase_q != gar_pkg::PH_PEND || relay_q) begin
          ev0 = gar_pkg::EV_AUTH_OPEN_REJ;
        end else begin
          armed_d = 1'b1;
          aw_d = item_i.first_duration;
          as_d = now_t;
          cw_d = item_i.cooldown_length;
          phase_d = gar_pkg::PH_ARMED;
          ps_d = now_t;
          acc = 1'b1;
          ev0 = gar_pkg::EV_AUTH_ARMED;
        end
      end
      gar_pkg::CMD_LOCAL_OPEN, gar_pkg::CMD_REMOTE_OPEN: begin
        n = 2'd1;
        if ((item_i.command == gar_pkg::CMD_LOCAL_OPEN && phase_q != gar_pkg::PH_PEND) ||
            (item_i.command == gar_pkg::CMD_REMOTE_OPEN && phase_q != gar_pkg::PH_IDLE) ||
            relay_q) begin
          ev0 = (item_i.command == gar_pkg::CMD_LOCAL_OPEN) ?
                gar_pkg::EV_LOCAL_OPEN_REJ : gar_pkg::EV_MANUAL_OPEN_REJ;
        end else begin
          armed_d = 1'b0;
          hw_d = item_i.first_duration;
          cw_d = item_i.cooldown_length;
          phase_d = gar_pkg::PH_HOLD;
          ps_d = now_t;
          relay_d = 1'b1;
          acc = 1'b1;
          ev0 = (item_i.command == gar_pkg::CMD_LOCAL_OPEN) ?
                gar_pkg::EV_RELAY_ON_LOCAL : gar_pkg::EV_RELAY_ON_MANUAL;
        end
      end
      gar_pkg::CMD_ABORT: begin
        if (phase_q == gar_pkg::PH_PEND) begin
          phase_d = gar_pkg::PH_IDLE;
          armed_d = 1'b0;
          ps_d = now_t;
          acc = 1'b1;
          n = 2'd1;
          ev0 = gar_pkg::EV_AUTH_ABORTED;
        end
      end
      gar_pkg::CMD_PREARM: begin
        if (phase_q == gar_pkg::PH_IDLE && !relay_q) begin
          armed_d = 1'b1;
          aw_d = item_i.first_duration;
          as_d = now_t;
          phase_d = gar_pkg::PH_ARMED;
          ps_d = now_t;
          acc = 1'b1;
          n = 2'd1;
          ev0 = gar_pkg::EV_PRE_ARMED;
        end
      end
      gar_pkg::CMD_SENSOR: begin
        if (phase_q == gar_pkg::PH_ARMED && armed_q) begin
          armed_d = 1'b0;
          hw_d = item_i.first_duration;
          cw_d = item_i.cooldown_length;
          phase_d = gar_pkg::PH_HOLD;
          ps_d = now_t;
          relay_d = 1'b1;
          acc = 1'b1;
          n = 2'd2;
          sensor_hit = 1'b1;
          ev0 = gar_pkg::EV_SENSOR_DETECTED;
          ev1 = gar_pkg::EV_RELAY_ON_SENSOR;
        end
      end
      gar_pkg::CMD_TIMER_OFF, gar_pkg::CMD_FAILSAFE: begin
        if (hold_on) begin
          relay_d = 1'b0;
          armed_d = 1'b0;
          cw_d = item_i.cooldown_length;
          phase_d = gar_pkg::PH_COOL;
          ps_d = now_t;
          acc = 1'b1;
          n = 2'd2;
          if (item_i.command == gar_pkg::CMD_FAILSAFE) begin
            ev0 = gar_pkg::EV_DOOR_CLOSE_FS;
            ev1 = gar_pkg::EV_SESSION_TERM_FS;
          end else begin
            ev0 = gar_pkg::EV_DOOR_CLOSE;
            ev1 = gar_pkg::EV_SESSION_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  // Result packing: the sensor's first result still shows the relay off.
  always_comb begin
    push_o.count = (n == 2'd0) ? 2'd1 : n;
    push_o.res0.event_code  = ev0;
    push_o.res0.accepted    = acc;
    push_o.res0.relay_on    = sensor_hit ? relay_q : relay_d;
    push_o.res0.gate_phase  = gar_pkg::phase_code(phase_d);
    push_o.res0.last_result = (n != 2'd2);
    push_o.res1.event_code  = ev1;
    push_o.res1.accepted    = acc;
    push_o.res1.relay_on    = relay_d;
    push_o.res1.gate_phase  = gar_pkg::phase_code(phase_d);
    push_o.res1.last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gar_pkg::PH_IDLE;
      armed_q <= 1'b0;
      relay_q <= 1'b0;
      ps_q <= '0;
      as_q <= '0;
      aw_q <= '0;
      hw_q <= '0;
      cw_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      armed_q <= armed_d;
      relay_q <= relay_d;
      ps_q <= ps_d;
      as_q <= as_d;
      aw_q <= aw_d;
      hw_q <= hw_d;
      cw_q <= cw_d;
    end
  end

  `GAR_ASSERT(a_phase_onehot, $onehot(phase_q), "phase register not one-hot")
  `GAR_ASSERT_IMP(a_relay_in_hold, relay_q, phase_q == gar_pkg::PH_HOLD, "relay on outside hold")
  `GAR_ASSERT_IMP(a_armed_in_armed, armed_q, phase_q == gar_pkg::PH_ARMED, "armed flag outside armed")

endmodule

`default_nettype wire

### rtl/gar_res_fifo.sv
`default_nettype none

`include "gate_access_relay_fsm_core_assert.svh"

module gar_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire gar_pkg::gar_push_t data_i,
  output logic                    room_o,   // space for a full pair
  output logic                    valid_o,
  input  wire logic               stall_i,
  output gar_pkg::gar_out_t       data_o
);

  gar_pkg::gar_out_t mem_q [gar_pkg::RQ_DEPTH];
  logic [gar_pkg::RQ_PTR_W-1:0] wr_q, rd_q;
  logic [gar_pkg::RQ_CNT_W-1:0] cnt_q, cnt_d;
  logic [gar_pkg::RQ_CNT_W-1:0] n_in;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= gar_pkg::RQ_CNT_W'(gar_pkg::RQ_DEPTH - 2));
  assign pop     = valid_o && !stall_i;
  assign n_in    = push_i ? gar_pkg::RQ_CNT_W'(data_i.count) : '0;
  assign cnt_d   = cnt_q + n_in - gar_pkg::RQ_CNT_W'(pop);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i.res0;
      if (data_i.count == 2'd2) begin
        mem_q[wr_q + gar_pkg::RQ_PTR_W'(1)] <= data_i.res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_in[gar_pkg::RQ_PTR_W-1:0];
      rd_q  <= rd_q + gar_pkg::RQ_PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  `GAR_ASSERT_IMP(a_no_overflow, push_i, cnt_q + n_in <= gar_pkg::RQ_CNT_W'(gar_pkg::RQ_DEPTH),
                  "result queue overflow")
  `GAR_ASSERT_IMP(a_push_nonempty, push_i, data_i.count != 2'd0, "push with no results")

endmodule

`default_nettype wire

### rtl/gate_access_relay_fsm_core.sv
// A command item is held in the input register until the queue has room; its results are
//   then written to the result queue, a second result behind the first.
// Throughput: one command item per cycle while the queue holds two items or fewer;
//   results leave one per cycle while out_stall_i is low.
// The output side is decoupled by a 4-entry result queue.
// Reset (rst_ni low, async): phase idle, relay off, timers and windows zero, queue empty.

`default_nettype none

module gate_access_relay_fsm_core #(
  parameter int unsigned TIME_BITS = gar_pkg::TIME_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire gar_pkg::gar_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gar_pkg::gar_out_t     out_data_o
);

  // Input register: holds one command until the queue has room for a full result pair.
  gar_pkg::gar_in_t   item_q;
  logic               vld_q, vld_d;
  logic               room, fire, take;
  gar_pkg::gar_push_t push;

  assign fire       = vld_q && room;
  assign in_stall_o = vld_q && !room;
  assign take       = in_valid_i && !in_stall_o;
  assign vld_d      = take ? 1'b1 : (fire ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  // Phase machine: state registers and single-pass next-state and result logic.
  gar_engine #(
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .push_o (push)
  );

  // Result queue: one or two items in per command, one item out per cycle while out_stall_i is low.
  gar_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire
